// ===== sv/kdt_pkg.sv =====
// shared types, constants and key/action codes for the keypad debounce menu
// no dependencies; used by every module of the block
package kdt_pkg;

    localparam int KEY_W        = 8;
    localparam int DBC_W        = 4;
    localparam int CFG_W        = 12;
    localparam int CFG_IDX_W    = 3;
    localparam int ACT_W        = 3;
    localparam int MODE_W       = 2;
    localparam int SEL_W        = 2;
    localparam int NUM_ITEMS    = 3;

    localparam int TH_WIDTH_DEF = 12;
    localparam int QUEUE_DEPTH  = 2;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_FLOOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VIB_FLOOR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CURR_FLOOR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_START = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VIB_START  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CURR_START = 3'd6;

    // register reset values
    localparam logic [DBC_W-1:0] DEBOUNCE_RST   = 4'd3;
    localparam logic [CFG_W-1:0] TEMP_FLOOR_RST = 12'd100;
    localparam logic [CFG_W-1:0] VIB_FLOOR_RST  = 12'd2;
    localparam logic [CFG_W-1:0] CURR_FLOOR_RST = 12'd2;
    localparam logic [CFG_W-1:0] TEMP_START_RST = 12'd300;
    localparam logic [CFG_W-1:0] VIB_START_RST  = 12'd20;
    localparam logic [CFG_W-1:0] CURR_START_RST = 12'd50;

    // key codes (ascii)
    localparam logic [KEY_W-1:0] KEY_NONE  = 8'h00;
    localparam logic [KEY_W-1:0] KEY_A     = 8'h41;
    localparam logic [KEY_W-1:0] KEY_B     = 8'h42;
    localparam logic [KEY_W-1:0] KEY_C     = 8'h43;
    localparam logic [KEY_W-1:0] KEY_STAR  = 8'h2A;
    localparam logic [KEY_W-1:0] KEY_HASH  = 8'h23;
    localparam logic [KEY_W-1:0] KEY_TWO   = 8'h32;
    localparam logic [KEY_W-1:0] KEY_EIGHT = 8'h38;

    // action codes
    localparam logic [ACT_W-1:0] ACT_NONE  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PAGE  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_RELAY = 3'd2;
    localparam logic [ACT_W-1:0] ACT_BEEP  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_ENTER = 3'd4;
    localparam logic [ACT_W-1:0] ACT_EXIT  = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SAVE  = 3'd6;

    // classified word from the debounce front to the menu back
    typedef struct packed {
        logic             reload;
        logic             fired;
        logic [KEY_W-1:0] key;
    } t_evt;

    // menu settings from the register bank
    typedef struct packed {
        logic [NUM_ITEMS-1:0][CFG_W-1:0] floor;
        logic [NUM_ITEMS-1:0][CFG_W-1:0] start;
    } t_menu_cfg;

    // one result word
    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic              key_fired;
        logic [KEY_W-1:0]  fired_key;
        logic [MODE_W-1:0] menu_mode;
        logic [SEL_W-1:0]  selected_item;
        logic [CFG_W-1:0]  temp_threshold;
        logic [CFG_W-1:0]  vib_threshold;
        logic [CFG_W-1:0]  curr_threshold;
    } t_result;

endpackage

// ===== sv/keypad_debounce_threshold_menu_core.sv =====
// top level of the keypad debounce and threshold menu block
// depends on kdt_pkg, kdt_front, kdt_queue, kdt_back
//
//  channel   direction  handshake                   payload
//  -------   ---------  --------------------------  -----------------------------------
//  in        sink       i_in_valid / o_in_stall     i_command, i_scan_key
//  out       source     o_out_valid / i_out_stall   o_action ... o_curr_threshold
//  cfg       sink       i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// one word accepted per cycle while o_in_stall is low; the front writes it into the queue,
// then the back reads it from there and loads its result into the output register
// the two-entry queue takes the front's word while a finished result waits
// synchronous active-low reset; thresholds come back at the saturated start values
// in stalls only while the queue is full; cfg is always ready
module keypad_debounce_threshold_menu_core #(
    parameter int THRESHOLD_WIDTH = kdt_pkg::TH_WIDTH_DEF,
    parameter int QUEUE_DEPTH     = kdt_pkg::QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input words
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_command,
    input  logic [kdt_pkg::KEY_W-1:0]       i_scan_key,
    // result words
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [kdt_pkg::ACT_W-1:0]       o_action,
    output logic                            o_key_fired,
    output logic [kdt_pkg::KEY_W-1:0]       o_fired_key,
    output logic [kdt_pkg::MODE_W-1:0]      o_menu_mode,
    output logic [kdt_pkg::SEL_W-1:0]       o_selected_item,
    output logic [kdt_pkg::CFG_W-1:0]       o_temp_threshold,
    output logic [kdt_pkg::CFG_W-1:0]       o_vib_threshold,
    output logic [kdt_pkg::CFG_W-1:0]       o_curr_threshold,
    // register writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [kdt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [kdt_pkg::CFG_W-1:0]       i_cfg_data
);

    // register bank
    logic [kdt_pkg::DBC_W-1:0] r_debounce;
    kdt_pkg::t_menu_cfg        r_menu_cfg;

    // front to queue to back
    logic             w_push;
    logic             w_q_full;
    logic             w_q_valid;
    logic             w_pop;
    kdt_pkg::t_evt    w_front_evt;
    kdt_pkg::t_evt    w_q_evt;
    kdt_pkg::t_result w_res;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = w_q_full;

    // register writes; an index past the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce          <= kdt_pkg::DEBOUNCE_RST;
            r_menu_cfg.floor[0] <= kdt_pkg::TEMP_FLOOR_RST;
            r_menu_cfg.floor[1] <= kdt_pkg::VIB_FLOOR_RST;
            r_menu_cfg.floor[2] <= kdt_pkg::CURR_FLOOR_RST;
            r_menu_cfg.start[0] <= kdt_pkg::TEMP_START_RST;
            r_menu_cfg.start[1] <= kdt_pkg::VIB_START_RST;
            r_menu_cfg.start[2] <= kdt_pkg::CURR_START_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                kdt_pkg::REG_DEBOUNCE:   r_debounce          <= i_cfg_data[kdt_pkg::DBC_W-1:0];
                kdt_pkg::REG_TEMP_FLOOR: r_menu_cfg.floor[0] <= i_cfg_data;
                kdt_pkg::REG_VIB_FLOOR:  r_menu_cfg.floor[1] <= i_cfg_data;
                kdt_pkg::REG_CURR_FLOOR: r_menu_cfg.floor[2] <= i_cfg_data;
                kdt_pkg::REG_TEMP_START: r_menu_cfg.start[0] <= i_cfg_data;
                kdt_pkg::REG_VIB_START:  r_menu_cfg.start[1] <= i_cfg_data;
                kdt_pkg::REG_CURR_START: r_menu_cfg.start[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // debounce and classification
    kdt_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_full           (w_q_full),
        .i_command        (i_command),
        .i_scan_key       (i_scan_key),
        .i_debounce_count (r_debounce),
        .o_push           (w_push),
        .o_evt            (w_front_evt)
    );

    // decoupling queue
    kdt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_evt   (w_front_evt),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_full  (w_q_full),
        .o_evt   (w_q_evt)
    );

    // menu and thresholds
    kdt_back #(
        .TW (THRESHOLD_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_evt       (w_q_evt),
        .i_cfg       (r_menu_cfg),
        .i_out_stall (i_out_stall),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_res       (w_res)
    );

    assign o_action         = w_res.action;
    assign o_key_fired      = w_res.key_fired;
    assign o_fired_key      = w_res.fired_key;
    assign o_menu_mode      = w_res.menu_mode;
    assign o_selected_item  = w_res.selected_item;
    assign o_temp_threshold = w_res.temp_threshold;
    assign o_vib_threshold  = w_res.vib_threshold;
    assign o_curr_threshold = w_res.curr_threshold;

    // an action only comes from a fired key
    a_action_needs_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_action != kdt_pkg::ACT_NONE) |-> o_key_fired)
        else $error("action without a fired key");

    // no fire means no key code
    a_no_fire_no_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_key_fired) |-> (o_fired_key == kdt_pkg::KEY_NONE))
        else $error("key code without a fire");

    // a new result needs a queued word the cycle before
    a_result_from_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_q_valid))
        else $error("result appeared with an empty queue");

    // the queue never takes a word while full
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_full |-> !w_push)
        else $error("push into a full queue");

endmodule

// ===== sv/kdt_front.sv =====
// debounce front: accepts scan words, tracks repeats, classifies each word
// depends on kdt_pkg
module kdt_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_full,
    input  logic                        i_command,
    input  logic [kdt_pkg::KEY_W-1:0]   i_scan_key,
    input  logic [kdt_pkg::DBC_W-1:0]   i_debounce_count,
    output logic                        o_push,
    output kdt_pkg::t_evt               o_evt
);

    logic [kdt_pkg::KEY_W-1:0] r_prev_key, n_prev_key;
    logic [kdt_pkg::DBC_W-1:0] r_same_cnt, n_same_cnt;
    logic [kdt_pkg::DBC_W-1:0] w_inc;
    logic                      w_fired;

    assign o_push = i_in_valid && !i_full;
    assign w_inc  = r_same_cnt + kdt_pkg::DBC_W'(1);

    always_comb begin
        n_prev_key = r_prev_key;
        n_same_cnt = r_same_cnt;
        w_fired    = 1'b0;
        if (i_command) begin
            // reload leaves debounce state alone
        end else if (i_scan_key == kdt_pkg::KEY_NONE) begin
            n_prev_key = kdt_pkg::KEY_NONE;
            n_same_cnt = '0;
        end else if (i_scan_key == r_prev_key) begin
            if (w_inc >= i_debounce_count) begin
                n_same_cnt = '0;
                w_fired    = 1'b1;
            end else begin
                n_same_cnt = w_inc;
            end
        end else begin
            n_prev_key = i_scan_key;
            n_same_cnt = kdt_pkg::DBC_W'(1);
        end
    end

    assign o_evt.reload = i_command;
    assign o_evt.fired  = w_fired;
    assign o_evt.key    = i_scan_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_key <= kdt_pkg::KEY_NONE;
            r_same_cnt <= '0;
        end else if (o_push) begin
            r_prev_key <= n_prev_key;
            r_same_cnt <= n_same_cnt;
        end
    end

endmodule

// ===== sv/kdt_queue.sv =====
// short fifo of classified words between the front and the back
// depends on kdt_pkg
module kdt_queue #(
    parameter int DEPTH = kdt_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  kdt_pkg::t_evt i_evt,
    input  logic          i_pop,
    output logic          o_valid,
    output logic          o_full,
    output kdt_pkg::t_evt o_evt
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    kdt_pkg::t_evt r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_evt   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// ===== sv/kdt_back.sv =====
// menu back: mode, selection and thresholds, plus the result register
// depends on kdt_pkg
module kdt_back #(
    parameter int TW = kdt_pkg::TH_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  kdt_pkg::t_evt      i_evt,
    input  kdt_pkg::t_menu_cfg i_cfg,
    input  logic               i_out_stall,
    output logic               o_pop,
    output logic               o_out_valid,
    output kdt_pkg::t_result   o_res
);

    localparam int CW = kdt_pkg::CFG_W;
    localparam int NI = kdt_pkg::NUM_ITEMS;
    localparam logic [TW-1:0] TH_MAX = {TW{1'b1}};

    typedef enum logic [kdt_pkg::MODE_W-1:0] {
        M_NORMAL = 2'd0,
        M_SELECT = 2'd1,
        M_ADJUST = 2'd2
    } t_mode;

    function automatic logic [TW-1:0] f_sat(input logic [CW-1:0] s);
        logic [TW+CW-1:0] w;
        w = {{TW{1'b0}}, s};
        if (w > {{CW{1'b0}}, TH_MAX}) begin
            return TH_MAX;
        end
        return w[TW-1:0];
    endfunction

    function automatic logic [CW-1:0] f_out(input logic [TW-1:0] v);
        logic [TW+CW-1:0] w;
        w = {{CW{1'b0}}, v};
        return w[CW-1:0];
    endfunction

    t_mode                       r_mode, n_mode;
    logic [kdt_pkg::SEL_W-1:0]   r_sel, n_sel;
    logic [TW-1:0]               r_val [NI];
    logic [TW-1:0]               n_val [NI];
    logic [kdt_pkg::ACT_W-1:0]   w_act;
    kdt_pkg::t_result            r_res, n_res;
    logic                        r_out_valid;

    assign o_pop       = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

    always_comb begin
        n_mode = r_mode;
        n_sel  = r_sel;
        w_act  = kdt_pkg::ACT_NONE;
        for (int i = 0; i < NI; i++) begin
            n_val[i] = r_val[i];
        end
        if (i_evt.reload) begin
            for (int i = 0; i < NI; i++) begin
                n_val[i] = f_sat(i_cfg.start[i]);
            end
        end else if (i_evt.fired) begin
            unique case (r_mode)
                M_NORMAL: begin
                    case (i_evt.key) inside
                        kdt_pkg::KEY_A: w_act = kdt_pkg::ACT_PAGE;
                        kdt_pkg::KEY_B: w_act = kdt_pkg::ACT_RELAY;
                        kdt_pkg::KEY_C: w_act = kdt_pkg::ACT_BEEP;
                        kdt_pkg::KEY_STAR: begin
                            w_act  = kdt_pkg::ACT_ENTER;
                            n_mode = M_SELECT;
                            n_sel  = '0;
                        end
                        default: ;
                    endcase
                end
                M_SELECT: begin
                    case (i_evt.key) inside
                        kdt_pkg::KEY_TWO: begin
                            // up: (sel + 2) mod 3
                            case (r_sel)
                                2'd0:    n_sel = 2'd2;
                                2'd1:    n_sel = 2'd0;
                                2'd2:    n_sel = 2'd1;
                                default: n_sel = 2'd2;
                            endcase
                        end
                        kdt_pkg::KEY_EIGHT: begin
                            // down: (sel + 1) mod 3
                            case (r_sel)
                                2'd0:    n_sel = 2'd1;
                                2'd1:    n_sel = 2'd2;
                                2'd2:    n_sel = 2'd0;
                                default: n_sel = 2'd1;
                            endcase
                        end
                        kdt_pkg::KEY_A: n_mode = M_ADJUST;
                        kdt_pkg::KEY_STAR: begin
                            n_mode = M_NORMAL;
                            w_act  = kdt_pkg::ACT_EXIT;
                        end
                        default: ;
                    endcase
                end
                M_ADJUST: begin
                    case (i_evt.key) inside
                        kdt_pkg::KEY_TWO, kdt_pkg::KEY_HASH: begin
                            for (int i = 0; i < NI; i++) begin
                                if (r_sel == kdt_pkg::SEL_W'(i) && r_val[i] != TH_MAX) begin
                                    n_val[i] = r_val[i] + TW'(1);
                                end
                            end
                        end
                        kdt_pkg::KEY_EIGHT, kdt_pkg::KEY_STAR: begin
                            for (int i = 0; i < NI; i++) begin
                                if (r_sel == kdt_pkg::SEL_W'(i) &&
                                    {{CW{1'b0}}, r_val[i]} > {{TW{1'b0}}, i_cfg.floor[i]}) begin
                                    n_val[i] = r_val[i] - TW'(1);
                                end
                            end
                        end
                        kdt_pkg::KEY_A: begin
                            n_mode = M_SELECT;
                            w_act  = kdt_pkg::ACT_SAVE;
                        end
                        kdt_pkg::KEY_B: n_mode = M_SELECT;
                        default: ;
                    endcase
                end
                default: n_mode = M_NORMAL;
            endcase
        end
    end

    always_comb begin
        n_res.action         = w_act;
        n_res.key_fired      = i_evt.fired && !i_evt.reload;
        n_res.fired_key      = (i_evt.fired && !i_evt.reload) ? i_evt.key : kdt_pkg::KEY_NONE;
        n_res.menu_mode      = n_mode;
        n_res.selected_item  = n_sel;
        n_res.temp_threshold = f_out(n_val[0]);
        n_res.vib_threshold  = f_out(n_val[1]);
        n_res.curr_threshold = f_out(n_val[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= M_NORMAL;
            r_sel       <= '0;
            r_val[0]    <= f_sat(kdt_pkg::TEMP_START_RST);
            r_val[1]    <= f_sat(kdt_pkg::VIB_START_RST);
            r_val[2]    <= f_sat(kdt_pkg::CURR_START_RST);
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_mode      <= n_mode;
                r_sel       <= n_sel;
                for (int i = 0; i < NI; i++) begin
                    r_val[i] <= n_val[i];
                end
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_pop) begin
            r_res <= n_res;
        end
    end

endmodule
